/* design/rld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Shared widths, register map and types for the radial lens distortion remap.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int MAX_DIM   = 2048;
    localparam int COL_W     = 11;
    localparam int OUT_W     = 21;
    localparam int COEF_W    = 16;
    localparam int DIM_W     = 12;
    localparam int IHD_W     = 24;
    localparam int IHD_HALF  = 12;
    localparam int E_W       = 13;
    localparam int SQ_W      = 24;
    localparam int SUM_W     = 25;
    localparam int RAD_W     = 42;
    localparam int ROOT_W    = 21;
    localparam int REM_W     = 25;
    localparam int SQ_STAGES = 7;
    localparam int SQ_STEPS  = 3;
    localparam int RS_W      = 15;
    localparam int P1_W      = 20;
    localparam int P2_W      = 23;
    localparam int P3_W      = 26;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int N_STAGES  = 20;
    localparam int SQ_FIRST  = 3;
    localparam int POLY_FIRST = SQ_FIRST + SQ_STAGES;
    localparam int POLY_STAGES = N_STAGES - POLY_FIRST;

    typedef enum logic [2:0] {
        REG_CUBIC,
        REG_SQUARE,
        REG_LINEAR,
        REG_CONST,
        REG_WIDTH,
        REG_HEIGHT,
        REG_IHD
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef_cubic;
        logic [COEF_W-1:0] coef_square;
        logic [COEF_W-1:0] coef_linear;
        logic [COEF_W-1:0] coef_const;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [IHD_W-1:0]  inv_half_diag;
    } cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } dims_t;

    typedef struct packed {
        logic signed [E_W-1:0] ex;
        logic signed [E_W-1:0] ey;
    } tag_t;

endpackage

/* design/rld_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_apb_regs
// APB register file holding the polynomial coefficients, image size and
// reciprocal half diagonal.
// ----------------------------------------------------------------------------
module rld_apb_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rld_pkg::ADDR_W-1:0]  paddr,
    input  logic [rld_pkg::DATA_W-1:0]  pwdata,
    output logic [rld_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output rld_pkg::cfg_t               cfg
);
    import rld_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CUBIC:  cfg_next.coef_cubic    = pwdata[COEF_W-1:0];
                REG_SQUARE: cfg_next.coef_square   = pwdata[COEF_W-1:0];
                REG_LINEAR: cfg_next.coef_linear   = pwdata[COEF_W-1:0];
                REG_CONST:  cfg_next.coef_const    = pwdata[COEF_W-1:0];
                REG_WIDTH:  cfg_next.image_width   = pwdata[DIM_W-1:0];
                REG_HEIGHT: cfg_next.image_height  = pwdata[DIM_W-1:0];
                REG_IHD:    cfg_next.inv_half_diag = pwdata[IHD_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CUBIC:  prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_cubic};
            REG_SQUARE: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_square};
            REG_LINEAR: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_linear};
            REG_CONST:  prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_const};
            REG_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.image_width};
            REG_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.image_height};
            REG_IHD:    prdata = {{(DATA_W-IHD_W){1'b0}}, cfg_reg.inv_half_diag};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_cubic    <= '0;
            cfg_reg.coef_square   <= '0;
            cfg_reg.coef_linear   <= '0;
            cfg_reg.coef_const    <= 16'd4096;
            cfg_reg.image_width   <= 12'd2048;
            cfg_reg.image_height  <= 12'd2048;
            cfg_reg.inv_half_diag <= 24'd2896;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/rld_sqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_sqrt_pipe
// Pipelined digit-by-digit integer square root, three root bits per stage,
// with the pixel offsets carried alongside.
// ----------------------------------------------------------------------------
module rld_sqrt_pipe
(
    input  logic                                clk,
    input  logic [rld_pkg::SQ_STAGES-1:0]       en,
    input  logic [rld_pkg::RAD_W-1:0]           rad_in,
    input  rld_pkg::tag_t                       tag_in,
    output logic [rld_pkg::ROOT_W-1:0]          root,
    output rld_pkg::tag_t                       tag_out
);
    import rld_pkg::*;

    logic [REM_W-1:0]  rem_i    [SQ_STAGES];
    logic [ROOT_W-1:0] root_i   [SQ_STAGES];
    logic [RAD_W-1:0]  rad_i    [SQ_STAGES];
    tag_t              tag_i    [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQ_STAGES];
    tag_t              tag_reg  [SQ_STAGES];
    logic [REM_W-1:0]  rem_next [SQ_STAGES];
    logic [ROOT_W-1:0] root_next[SQ_STAGES];
    logic [RAD_W-1:0]  rad_next [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_stage
        logic [REM_W-1:0]  r;
        logic [REM_W-1:0]  t;
        logic [ROOT_W-1:0] q;
        logic [RAD_W-1:0]  v;

        if (g == 0)
        begin : g_first
            assign rem_i[g]  = '0;
            assign root_i[g] = '0;
            assign rad_i[g]  = rad_in;
            assign tag_i[g]  = tag_in;
        end
        else
        begin : g_rest
            assign rem_i[g]  = rem_reg[g-1];
            assign root_i[g] = root_reg[g-1];
            assign rad_i[g]  = rad_reg[g-1];
            assign tag_i[g]  = tag_reg[g-1];
        end

        always_comb
        begin
            r = rem_i[g];
            q = root_i[g];
            v = rad_i[g];
            t = '0;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                // bring down the next two radicand bits, try root*4+1
                r = {r[REM_W-3:0], v[RAD_W-1 -: 2]};
                v = {v[RAD_W-3:0], 2'b00};
                t = {{(REM_W-ROOT_W-2){1'b0}}, q, 2'b01};
                if (r >= t)
                begin
                    r = r - t;
                    q = {q[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[ROOT_W-2:0], 1'b0};
                end
            end
            rem_next[g]  = r;
            root_next[g] = q;
            rad_next[g]  = v;
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                rem_reg[g]  <= rem_next[g];
                root_reg[g] <= root_next[g];
                rad_reg[g]  <= rad_next[g];
                tag_reg[g]  <= tag_i[g];
            end
        end
    end

    assign root    = root_reg[SQ_STAGES-1];
    assign tag_out = tag_reg[SQ_STAGES-1];

endmodule

/* design/rld_poly_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_poly_pipe
// Radius scaling, Horner evaluation of the cubic and source coordinate
// rounding with saturation and bounds check.
// ----------------------------------------------------------------------------
module rld_poly_pipe
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                                  clk,
    input  logic [rld_pkg::POLY_STAGES-1:0]       en,
    input  rld_pkg::cfg_t                         cfg,
    input  rld_pkg::dims_t                        dims,
    input  logic [rld_pkg::ROOT_W-1:0]            root,
    input  rld_pkg::tag_t                         tag_in,
    output logic signed [rld_pkg::OUT_W-1:0]      src_x,
    output logic signed [rld_pkg::OUT_W-1:0]      src_y,
    output logic                                  inside_res
);
    import rld_pkg::*;

    localparam int CW    = 48;
    localparam int SH    = 13 - FRAC_BITS;
    localparam int PP_W  = ROOT_W + IHD_HALF;
    localparam int TOT_W = PP_W + IHD_HALF + 1;
    localparam int M1_W  = COEF_W + RS_W + 1;
    localparam int M2_W  = P1_W + RS_W + 1;
    localparam int M3_W  = P2_W + RS_W + 1;
    localparam int MC_W  = E_W + P3_W;
    localparam int N_TAG = POLY_STAGES - 2;
    localparam int N_RS  = 4;
    localparam logic [RS_W-1:0]    RS_MAX  = {RS_W{1'b1}};
    localparam logic signed [CW-1:0] OUT_MIN = -48'sd1048576;
    localparam logic signed [CW-1:0] OUT_MAX = 48'sd1048575;

    tag_t                     tag_reg [N_TAG];
    logic [RS_W-1:0]          rsd_reg [N_RS];

    logic [PP_W-1:0]          pp_lo_reg, pp_lo_next;
    logic [PP_W-1:0]          pp_hi_reg, pp_hi_next;
    logic [TOT_W-1:0]         total;
    logic [TOT_W-20:0]        rs_wide;
    logic [RS_W-1:0]          rs_reg, rs_next;
    logic signed [M1_W-1:0]   m1_reg, m1_next, t1;
    logic signed [P1_W-1:0]   p1_reg, p1_next;
    logic signed [M2_W-1:0]   m2_reg, m2_next, t2;
    logic signed [P2_W-1:0]   p2_reg, p2_next;
    logic signed [M3_W-1:0]   m3_reg, m3_next, t3;
    logic signed [P3_W-1:0]   p3_reg, p3_next;
    logic signed [MC_W-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic signed [CW-1:0]     x_full, y_full, rx, ry, base_x, base_y, lim_x, lim_y;
    logic signed [OUT_W-1:0]  src_x_reg, src_x_next, src_y_reg, src_y_next;
    logic                     inside_reg, inside_next;

    // radius times reciprocal split into two 12-bit halves
    assign pp_lo_next = root * cfg.inv_half_diag[IHD_HALF-1:0];
    assign pp_hi_next = root * cfg.inv_half_diag[IHD_W-1:IHD_HALF];

    assign total   = {1'b0, pp_hi_reg, {IHD_HALF{1'b0}}}
                   + {{(IHD_HALF+1){1'b0}}, pp_lo_reg}
                   + TOT_W'(1 << 18);
    assign rs_wide = total[TOT_W-1:19];
    assign rs_next = (rs_wide > {{(TOT_W-19-RS_W){1'b0}}, RS_MAX})
                   ? RS_MAX : rs_wide[RS_W-1:0];

    // horner: multiply stage, then round-half-up and add stage
    assign m1_next = $signed(cfg.coef_cubic) * $signed({1'b0, rs_reg});
    assign t1      = m1_reg + M1_W'(2048);
    assign p1_next = P1_W'((t1 >>> 12)
                   + $signed({{(M1_W-COEF_W){cfg.coef_square[COEF_W-1]}}, cfg.coef_square}));

    assign m2_next = p1_reg * $signed({1'b0, rsd_reg[1]});
    assign t2      = m2_reg + M2_W'(2048);
    assign p2_next = P2_W'((t2 >>> 12)
                   + $signed({{(M2_W-COEF_W){cfg.coef_linear[COEF_W-1]}}, cfg.coef_linear}));

    assign m3_next = p2_reg * $signed({1'b0, rsd_reg[3]});
    assign t3      = m3_reg + M3_W'(2048);
    assign p3_next = P3_W'((t3 >>> 12)
                   + $signed({{(M3_W-COEF_W){cfg.coef_const[COEF_W-1]}}, cfg.coef_const}));

    assign mx_next = tag_reg[N_TAG-1].ex * p3_reg;
    assign my_next = tag_reg[N_TAG-1].ey * p3_reg;

    // centre plus scaled offset plus one half, in FRAC_BITS fixed point
    assign base_x = $signed((CW'(dims.w) << (FRAC_BITS-1)) + (CW'(1) << (FRAC_BITS-1)));
    assign base_y = $signed((CW'(dims.h) << (FRAC_BITS-1)) + (CW'(1) << (FRAC_BITS-1)));
    assign lim_x  = $signed(CW'(dims.w) << FRAC_BITS);
    assign lim_y  = $signed(CW'(dims.h) << FRAC_BITS);
    assign rx     = ($signed({{(CW-MC_W){mx_reg[MC_W-1]}}, mx_reg})
                   + $signed(CW'(1) << (SH-1))) >>> SH;
    assign ry     = ($signed({{(CW-MC_W){my_reg[MC_W-1]}}, my_reg})
                   + $signed(CW'(1) << (SH-1))) >>> SH;
    assign x_full = base_x + rx;
    assign y_full = base_y + ry;

    always_comb
    begin
        if (x_full < OUT_MIN)
            src_x_next = OUT_MIN[OUT_W-1:0];
        else if (x_full > OUT_MAX)
            src_x_next = OUT_MAX[OUT_W-1:0];
        else
            src_x_next = x_full[OUT_W-1:0];
        if (y_full < OUT_MIN)
            src_y_next = OUT_MIN[OUT_W-1:0];
        else if (y_full > OUT_MAX)
            src_y_next = OUT_MAX[OUT_W-1:0];
        else
            src_y_next = y_full[OUT_W-1:0];
        inside_next = !x_full[CW-1] && !y_full[CW-1] && (x_full < lim_x) && (y_full < lim_y);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0] <= tag_in;
            pp_lo_reg  <= pp_lo_next;
            pp_hi_reg  <= pp_hi_next;
        end
        for (int k = 1; k < N_TAG; k++)
        begin
            if (en[k])
                tag_reg[k] <= tag_reg[k-1];
        end
        if (en[1])
            rs_reg <= rs_next;
        if (en[2])
        begin
            rsd_reg[0] <= rs_reg;
            m1_reg     <= m1_next;
        end
        for (int k = 1; k < N_RS; k++)
        begin
            if (en[k+2])
                rsd_reg[k] <= rsd_reg[k-1];
        end
        if (en[3])
            p1_reg <= p1_next;
        if (en[4])
            m2_reg <= m2_next;
        if (en[5])
            p2_reg <= p2_next;
        if (en[6])
            m3_reg <= m3_next;
        if (en[7])
            p3_reg <= p3_next;
        if (en[8])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
        if (en[9])
        begin
            src_x_reg  <= src_x_next;
            src_y_reg  <= src_y_next;
            inside_reg <= inside_next;
        end
    end

    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;

endmodule

/* design/radial_lens_distortion_remap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_lens_distortion_remap
// Maps an output pixel to its source coordinate through a cubic radial
// distortion polynomial.
// ----------------------------------------------------------------------------
// Takes one pixel coordinate per clock and returns one source coordinate per
// clock while the output is not stalled. The latency is set by the offset,
// square and sum stages, the square root, seven stages of three root bits
// each, the multiply and round stages of the radius scaling, the three
// Horner steps and the coordinate scaling. A stall on the output fills
// empty stages first; the input stalls only once every stage holds a pixel.
// Write registers over APB only while no pixel is in flight (not enforced).
module radial_lens_distortion_remap
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rld_pkg::ADDR_W-1:0]            paddr,
    input  logic [rld_pkg::DATA_W-1:0]            pwdata,
    output logic [rld_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rld_pkg::COL_W-1:0]             col,
    input  logic [rld_pkg::COL_W-1:0]             row,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rld_pkg::OUT_W-1:0]      src_x,
    output logic signed [rld_pkg::OUT_W-1:0]      src_y,
    output logic                                  inside_res
);
    import rld_pkg::*;

    localparam logic [DIM_W+1:0] MAX_V = (DIM_W+2)'(MAX_DIM);

    cfg_t                   cfg;
    dims_t                  dims;
    logic [N_STAGES-1:0]    en;
    logic [N_STAGES-1:0]    valid_reg, valid_next;
    tag_t                   tag0_reg, tag0_next, tag1_reg, tag2_reg, sq_tag;
    logic signed [2*E_W-1:0] prod_x, prod_y;
    logic [SQ_W-1:0]        sq_x_reg, sq_y_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [ROOT_W-1:0]      root;

    rld_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero size acts as one, oversize as MAX_DIM
    always_comb
    begin
        if (cfg.image_width == '0)
            dims.w = DIM_W'(1);
        else if ({2'b00, cfg.image_width} > MAX_V)
            dims.w = MAX_V[DIM_W-1:0];
        else
            dims.w = cfg.image_width;
        if (cfg.image_height == '0)
            dims.h = DIM_W'(1);
        else if ({2'b00, cfg.image_height} > MAX_V)
            dims.h = MAX_V[DIM_W-1:0];
        else
            dims.h = cfg.image_height;
    end

    // a stage advances when empty or when the stage after it advances
    always_comb
    begin
        en[N_STAGES-1] = !valid_reg[N_STAGES-1] || !out_stall;
        for (int k = N_STAGES-2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N_STAGES; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[N_STAGES-1];

    // offsets in half-pixel units
    assign tag0_next.ex = $signed({1'b0, col, 1'b0}) - $signed({1'b0, dims.w});
    assign tag0_next.ey = $signed({1'b0, row, 1'b0}) - $signed({1'b0, dims.h});
    assign prod_x       = tag0_reg.ex * tag0_reg.ex;
    assign prod_y       = tag0_reg.ey * tag0_reg.ey;
    assign sum_next     = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
            tag0_reg <= tag0_next;
        if (en[1])
        begin
            tag1_reg <= tag0_reg;
            sq_x_reg <= prod_x[SQ_W-1:0];
            sq_y_reg <= prod_y[SQ_W-1:0];
        end
        if (en[2])
        begin
            tag2_reg <= tag1_reg;
            sum_reg  <= sum_next;
        end
    end

    rld_sqrt_pipe u_sqrt
    (
        .clk     (clk),
        .en      (en[POLY_FIRST-1:SQ_FIRST]),
        .rad_in  ({{(RAD_W-SUM_W-16){1'b0}}, sum_reg, 16'h0000}),
        .tag_in  (tag2_reg),
        .root    (root),
        .tag_out (sq_tag)
    );

    rld_poly_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly
    (
        .clk        (clk),
        .en         (en[N_STAGES-1:POLY_FIRST]),
        .cfg        (cfg),
        .dims       (dims),
        .root       (root),
        .tag_in     (sq_tag),
        .src_x      (src_x),
        .src_y      (src_y),
        .inside_res (inside_res)
    );

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled while the pipeline has an empty stage");

    a_inside_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_res) |-> (!src_x[OUT_W-1] && !src_y[OUT_W-1]))
        else $error("inside flag set on a negative coordinate");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (en[N_STAGES-1] && valid_reg[N_STAGES-2]) |=> out_valid)
        else $error("pixel lost entering the output stage");
`endif

endmodule
